// ===== design/ddf_pkg.sv =====
// ddf_pkg: shared types and constants for the sequence duplicate filter
// no dependencies; used by every module of the filter but the ddf_chk checker
`timescale 1ns / 1ps

package ddf_pkg;

	localparam int RING_DEPTH = 16;
	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SEQ_W      = 16;
	localparam int TIME_W     = 32;
	localparam int AGE_W      = 16;
	localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(500);
	localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] stamp;
	} ddf_entry_t;

	typedef struct packed {
		logic [RING_AW-1:0] rd_addr;
		logic               wr_en;
		logic [RING_AW-1:0] wr_addr;
	} ddf_ring_ctl_t;

	typedef struct packed {
		logic clear;
		logic en;
	} ddf_cmp_ctl_t;

endpackage

// ===== design/sequence_duplicate_filter_core.sv =====
// sequence_duplicate_filter_core: top level of the duplicate packet filter
// depends on ddf_pkg, ddf_ring, ddf_match and ddf_ctrl
//
//  channel   handshake                   payload
//  command   start / busy                seq_num[15:0], now_ms[31:0]
//  result    done (one-cycle strobe)     is_duplicate
//  config    cfg_valid / cfg_ready       cfg_data[15:0] (max_age_ms)
//
// an item runs through the scan of every ring entry, a drain state and a done state before done
// rises; set by the scan of the ring through one read port and one comparator
// a new start is accepted in the cycle where done is high
// arst_n clears the ring valid bits, write pointer, sequencer and sets max age to 500
// the result receiver cannot stall; cfg_ready is always high
`timescale 1ns / 1ps

module sequence_duplicate_filter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ddf_pkg::SEQ_W-1:0]    seq_num,
	input  logic [ddf_pkg::TIME_W-1:0]   now_ms,
	output logic                         done,
	output logic                         is_duplicate,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ddf_pkg::AGE_W-1:0]    cfg_data
);

	logic [ddf_pkg::SEQ_W-1:0]  seq_q;
	logic [ddf_pkg::TIME_W-1:0] now_q;
	logic [ddf_pkg::AGE_W-1:0]  max_age_q;
	logic hit;
	ddf_pkg::ddf_ring_ctl_t ring_ctl;
	ddf_pkg::ddf_cmp_ctl_t  cmp_ctl;
	ddf_pkg::ddf_entry_t    rd_entry;
	ddf_pkg::ddf_entry_t    wr_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= ddf_pkg::MAX_AGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_age_q <= cfg_data;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			seq_q <= seq_num;
			now_q <= now_ms;
		end
	end

	assign wr_entry.seq   = seq_q;
	assign wr_entry.stamp = now_q;

	ddf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.hit          (hit),
		.busy         (busy),
		.done         (done),
		.is_duplicate (is_duplicate),
		.ring_ctl     (ring_ctl),
		.cmp_ctl      (cmp_ctl)
	);

	ddf_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.wr_data (wr_entry),
		.rd_data (rd_entry)
	);

	ddf_match u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cmp_ctl),
		.entry   (rd_entry),
		.seq     (seq_q),
		.now     (now_q),
		.max_age (max_age_q),
		.hit     (hit)
	);

endmodule

// ===== design/ddf_ring.sv =====
// ddf_ring: ring of recent (sequence, stamp) entries with registered read
// depends on ddf_pkg; per-entry valid bits make unwritten entries read as zero
`timescale 1ns / 1ps

module ddf_ring (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ddf_pkg::ddf_ring_ctl_t ctl,
	input  ddf_pkg::ddf_entry_t   wr_data,
	output ddf_pkg::ddf_entry_t   rd_data
);

	ddf_pkg::ddf_entry_t mem [ddf_pkg::RING_DEPTH];
	logic [ddf_pkg::RING_DEPTH-1:0] vld_q;
	ddf_pkg::ddf_entry_t rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		rd_q <= mem[ctl.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				vld_q[ctl.wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[ctl.rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== design/ddf_match.sv =====
// ddf_match: shared age-and-sequence comparator with hit accumulator
// depends on ddf_pkg; one ring entry is checked per enabled cycle
`timescale 1ns / 1ps

module ddf_match (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ddf_pkg::ddf_cmp_ctl_t       ctl,
	input  ddf_pkg::ddf_entry_t         entry,
	input  logic [ddf_pkg::SEQ_W-1:0]   seq,
	input  logic [ddf_pkg::TIME_W-1:0]  now,
	input  logic [ddf_pkg::AGE_W-1:0]   max_age,
	output logic                        hit
);

	logic [ddf_pkg::TIME_W-1:0] age;
	logic match;
	logic hit_q;

	// wrapping age, so time going backwards never matches
	assign age   = now - entry.stamp;
	assign match = (entry.seq == seq) &&
		(age < {{(ddf_pkg::TIME_W - ddf_pkg::AGE_W){1'b0}}, max_age});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (ctl.en && match) begin
			hit_q <= 1'b1;
		end
	end

	assign hit = hit_q;

endmodule

// ===== design/ddf_ctrl.sv =====
// ddf_ctrl: sequencer that scans the ring, then reports and records non-duplicates
// depends on ddf_pkg; drives the ring and comparator control structs
`timescale 1ns / 1ps

module ddf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   hit,
	output logic                   busy,
	output logic                   done,
	output logic                   is_duplicate,
	output ddf_pkg::ddf_ring_ctl_t ring_ctl,
	output ddf_pkg::ddf_cmp_ctl_t  cmp_ctl
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic [ddf_pkg::RING_AW-1:0] scan_q;
	logic [ddf_pkg::RING_AW-1:0] wptr_q;
	logic issued_q;
	logic done_q;
	logic dup_q;
	logic accept;

	assign accept = start && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			scan_q   <= '0;
			wptr_q   <= '0;
			issued_q <= 1'b0;
			done_q   <= 1'b0;
			dup_q    <= 1'b0;
		end else begin
			done_q   <= (state_q == S_DONE);
			issued_q <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_q == ddf_pkg::RING_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					dup_q  <= hit;
					if (!hit) begin
						wptr_q <= (wptr_q == ddf_pkg::RING_LAST) ? '0 : wptr_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign is_duplicate = dup_q;

	assign ring_ctl.rd_addr = scan_q;
	assign ring_ctl.wr_en   = (state_q == S_DONE) && !hit;
	assign ring_ctl.wr_addr = wptr_q;

	assign cmp_ctl.clear = accept;
	assign cmp_ctl.en    = issued_q;

endmodule

// ===== design/ddf_chk.sv =====
// ddf_chk: port-level checks on command and result timing of the filter
// depends on sequence_duplicate_filter_core; attached by the bind below
`timescale 1ns / 1ps

module ddf_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// accepted transfer starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// result only once work is over
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// end of work always delivers a result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("work ended without a result");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind sequence_duplicate_filter_core ddf_chk u_ddf_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for sequence_duplicate_filter_core
// directed table then random traffic; depends on ddf_pkg and the filter rtl
`timescale 1ns / 1ps

module testbench;
	import ddf_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_PACKETS  = 75;
	localparam int PHASES         = 6;

	typedef enum logic {ROW_PACKET, ROW_CONFIG} row_kind_e;

	typedef struct packed {
		row_kind_e         kind;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] now;
		logic [AGE_W-1:0]  age;
		logic              known;
		logic              dup;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [SEQ_W-1:0]  seq_num = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic              done;
	logic              is_duplicate;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [AGE_W-1:0]  cfg_data = '0;

	// expectation override for table rows, driven alongside the packet fields
	logic known_valid = 1'b0;
	logic known_dup = 1'b0;

	// shadow of the filter state
	logic [SEQ_W-1:0]   ring_seq [RING_DEPTH];
	logic [TIME_W-1:0]  ring_stamp [RING_DEPTH];
	logic [RING_AW-1:0] ring_wr;
	logic [AGE_W-1:0]   age_limit;

	bit        expected_dup [$];
	stim_row_t directed_rows [$];

	int errors = 0;
	int quiet_cycles = 0;
	int packets_sent = 0;
	int results_seen = 0;
	int dups_seen = 0;
	int cfg_writes = 0;
	bit want;
	bit pred;

	sequence_duplicate_filter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.seq_num      (seq_num),
		.now_ms       (now_ms),
		.done         (done),
		.is_duplicate (is_duplicate),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// duplicate decision for one accepted packet, plus ring update when it is not a duplicate
	function automatic bit filter_packet(input logic [SEQ_W-1:0] seq,
			input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] age;
		for (int i = 0; i < RING_DEPTH; i++) begin
			age = now - ring_stamp[i];
			if (ring_seq[i] == seq && age < {{(TIME_W-AGE_W){1'b0}}, age_limit})
				return 1'b1;
		end
		ring_seq[ring_wr] = seq;
		ring_stamp[ring_wr] = now;
		ring_wr = (ring_wr == RING_LAST) ? '0 : ring_wr + 1'b1;
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (done === 1'b1) begin
				quiet_cycles = 0;
				results_seen++;
				if (expected_dup.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing pending, is_duplicate=%b",
						results_seen, is_duplicate));
				end else begin
					want = expected_dup.pop_front();
					if (is_duplicate !== want)
						report_mismatch($sformatf("result %0d is_duplicate=%b, want %b",
							results_seen, is_duplicate, want));
					if (want)
						dups_seen++;
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				quiet_cycles = 0;
				pred = filter_packet(seq_num, now_ms);
				expected_dup.push_back(known_valid ? known_dup : pred);
			end
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				quiet_cycles = 0;
				age_limit = cfg_data;
				cfg_writes++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("sequence_duplicate_filter_core test failed");
				$finish;
			end
		end
	end

	// start stays high on return so back-to-back packets keep it asserted
	task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] now,
			input logic known, input logic dup);
		start <= 1'b1;
		seq_num <= seq;
		now_ms <= now;
		known_valid <= known;
		known_dup <= dup;
		do @(posedge clk); while (busy !== 1'b0);
		packets_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		known_valid <= 1'b0;
		while (expected_dup.size() != 0) @(posedge clk);
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic write_max_age(input logic [AGE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		stim_row_t         row;
		logic [AGE_W-1:0]  phase_age;
		logic [TIME_W-1:0] cur_time;
		logic [SEQ_W-1:0]  pool_base;
		logic [SEQ_W-1:0]  pkt_seq;
		logic [TIME_W-1:0] pkt_now;
		int                burst_left;
		int                pick;
		int                slot;

		for (int i = 0; i < RING_DEPTH; i++) begin
			ring_seq[i] = '0;
			ring_stamp[i] = '0;
		end
		ring_wr = '0;
		age_limit = MAX_AGE_RESET;

		// zeroed ring, age boundary, wrapped time, time going backwards, zero and extreme ages
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h0000, 32'h0000_0000, 16'h0, 1'b1, 1'b1});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h0000, 32'h0000_01F3, 16'h0, 1'b1, 1'b1});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h0000, 32'h0000_01F4, 16'h0, 1'b1, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h0000, 32'h0000_03E7, 16'h0, 1'b0, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'hFFFF, 32'hFFFF_FF00, 16'h0, 1'b1, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'hFFFF, 32'h0000_0010, 16'h0, 1'b1, 1'b1});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'hFFFF, 32'hFFFF_FE00, 16'h0, 1'b1, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h5A5A, 32'hA5A5_A5A5, 16'h0, 1'b1, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h5A5A, 32'hA5A5_A5A5, 16'h0, 1'b1, 1'b1});
		directed_rows.push_back(stim_row_t'{ROW_CONFIG, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h5A5A, 32'hA5A5_A5A5, 16'h0, 1'b1, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h5A5A, 32'hA5A5_A5A5, 16'h0, 1'b1, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_CONFIG, 16'h0000, 32'h0000_0000, 16'h0001, 1'b0, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h5A5A, 32'hA5A5_A5A5, 16'h0, 1'b1, 1'b1});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h5A5A, 32'hA5A5_A5A6, 16'h0, 1'b1, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_CONFIG, 16'h0000, 32'h0000_0000, 16'hFFFF, 1'b0, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h5A5A, 32'hA5A6_A5A4, 16'h0, 1'b0, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h5A5A, 32'hA5A6_A5A6, 16'h0, 1'b0, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h1234, 32'hFFFF_FFFF, 16'h0, 1'b0, 1'b0});
		directed_rows.push_back(stim_row_t'{ROW_PACKET, 16'h0000, 32'hFFFF_FFFF, 16'h0, 1'b0, 1'b0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CONFIG) begin
				drain_results();
				write_max_age(row.age);
			end else begin
				send_packet(row.seq, row.now, row.known, row.dup);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: phase_age = AGE_W'($urandom_range(2, 2000));
				1: phase_age = AGE_W'(1);
				2: phase_age = '1;
				3: phase_age = '0;
				4: phase_age = MAX_AGE_RESET;
				default: phase_age = AGE_W'($urandom_range(1, 65535));
			endcase
			drain_results();
			write_max_age(phase_age);
			// some phases start just below the time wrap
			cur_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 300000) : $urandom;
			pool_base = SEQ_W'($urandom);
			burst_left = $urandom_range(1, 30);
			for (int n = 0; n < PHASE_PACKETS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					pkt_seq = SEQ_W'($urandom);
					pkt_now = $urandom;
				end else if (pick < 25) begin
					// hit an entry right at or just under the age limit
					slot = $urandom_range(0, RING_DEPTH - 1);
					pkt_seq = ring_seq[slot];
					pkt_now = ring_stamp[slot] + {{(TIME_W-AGE_W){1'b0}}, age_limit}
						- $urandom_range(0, 1);
				end else begin
					cur_time = cur_time + $urandom_range(0, age_limit / 8 + 1);
					pkt_now = cur_time;
					pkt_seq = ($urandom_range(0, 3) == 0) ? SEQ_W'($urandom)
						: pool_base + SEQ_W'($urandom_range(0, 23));
				end
				send_packet(pkt_seq, pkt_now, 1'b0, 1'b0);
				if (n == PHASE_PACKETS / 2) begin
					drain_results();
				end else if (--burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					if ($urandom_range(0, 3) != 0) begin
						start <= 1'b0;
						repeat ($urandom_range(1, 25)) @(posedge clk);
					end
				end
			end
		end

		drain_results();
		repeat (RING_DEPTH + 8) @(posedge clk);

		$display("ran %0d packets (%0d flagged duplicate) across %0d max-age writes,",
			packets_sent, dups_seen, cfg_writes);
		$display("including zero, one, full-range ages, wrapped and backward time; %0d mismatches",
			errors);
		if (errors == 0 && expected_dup.size() == 0) begin
			$display("sequence_duplicate_filter_core test passed");
		end else begin
			$display("sequence_duplicate_filter_core test failed");
		end
		$finish;
	end

endmodule
